// ===== hdl/ssr_pkg.sv =====
// Shared types, constants and the control-store program for the shape span rasterizer.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
package ssr_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int COORD_W  = 11;   // signed row/column math, covers -1024..1023
  localparam int DIM_W    = 9;    // active canvas size, holds up to 511
  localparam int SIZE_W   = 7;    // span width / height / half width
  localparam int CNT_W    = 13;   // pixels_drawn
  localparam int CANVAS_W = 7;
  localparam int PC_W     = 6;

  localparam logic [7:0]          BLANK_PIXEL  = 8'd46;
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

  // register select (paddr bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_RECT    = 3'd1,
    MODE_UP_TRI  = 3'd2,
    MODE_DN_TRI  = 3'd3,
    MODE_DIAMOND = 3'd4,
    MODE_READ    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    SEQ_NEXT,      // pc + 1
    SEQ_JUMP,      // target
    SEQ_BRANCH,    // cond ? target : pc + 1
    SEQ_WAIT,      // cond ? pc : target
    SEQ_DISPATCH   // word accepted ? entry(mode) : pc
  } seq_t;

  typedef enum logic [2:0] {
    C_ROWS_ZERO,
    C_SPAN_EMPTY,
    C_COL_MORE,
    C_CLR_MORE,
    C_OUT_BUSY,
    C_W_ZERO
  } cond_t;

  typedef struct packed {
    seq_t            seq;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            rdy;        // take a command word
    logic            row_setup;  // clip the span of the current row
    logic            span_rect;  // span is x..x+w-1, else x-hw..x+hw
    logic            pix;        // write one pixel, advance column
    logic            row_step;   // next row
    logic            cy_down;    // row moves up the screen
    logic            hw_down;    // half width shrinks
    logic            clr;        // write one blank pixel of the sweep
    logic            dm_init1;   // diamond widening phase
    logic            dm_init2;   // diamond narrowing phase
    logic            emit;       // load result register
  } ctrl_word_t;

  typedef struct packed {
    logic       accept;
    logic [2:0] mode;
    logic       rows_zero;
    logic       span_empty;
    logic       col_more;
    logic       clr_more;
    logic       out_busy;
    logic       w_zero;
  } flags_t;

  // control store addresses
  localparam logic [PC_W-1:0] PC_IDLE      = 6'd0;
  localparam logic [PC_W-1:0] PC_RST_CLR   = 6'd1;
  localparam logic [PC_W-1:0] PC_RST_DONE  = 6'd2;
  localparam logic [PC_W-1:0] PC_CLR       = 6'd3;
  localparam logic [PC_W-1:0] PC_CLR_DONE  = 6'd4;
  localparam logic [PC_W-1:0] PC_RECT      = 6'd5;
  localparam logic [PC_W-1:0] PC_RE_ROW    = 6'd6;
  localparam logic [PC_W-1:0] PC_RE_SET    = 6'd7;
  localparam logic [PC_W-1:0] PC_RE_CHK    = 6'd8;
  localparam logic [PC_W-1:0] PC_RE_PIX    = 6'd9;
  localparam logic [PC_W-1:0] PC_RE_STEP   = 6'd10;
  localparam logic [PC_W-1:0] PC_UP_ROW    = 6'd11;
  localparam logic [PC_W-1:0] PC_UP_SET    = 6'd12;
  localparam logic [PC_W-1:0] PC_UP_CHK    = 6'd13;
  localparam logic [PC_W-1:0] PC_UP_PIX    = 6'd14;
  localparam logic [PC_W-1:0] PC_UP_STEP   = 6'd15;
  localparam logic [PC_W-1:0] PC_DN_ROW    = 6'd16;
  localparam logic [PC_W-1:0] PC_DN_SET    = 6'd17;
  localparam logic [PC_W-1:0] PC_DN_CHK    = 6'd18;
  localparam logic [PC_W-1:0] PC_DN_PIX    = 6'd19;
  localparam logic [PC_W-1:0] PC_DN_STEP   = 6'd20;
  localparam logic [PC_W-1:0] PC_DIA       = 6'd21;
  localparam logic [PC_W-1:0] PC_DA_ROW    = 6'd22;
  localparam logic [PC_W-1:0] PC_DA_SET    = 6'd23;
  localparam logic [PC_W-1:0] PC_DA_CHK    = 6'd24;
  localparam logic [PC_W-1:0] PC_DA_PIX    = 6'd25;
  localparam logic [PC_W-1:0] PC_DA_STEP   = 6'd26;
  localparam logic [PC_W-1:0] PC_DIA2      = 6'd27;
  localparam logic [PC_W-1:0] PC_DB_ROW    = 6'd28;
  localparam logic [PC_W-1:0] PC_DB_SET    = 6'd29;
  localparam logic [PC_W-1:0] PC_DB_CHK    = 6'd30;
  localparam logic [PC_W-1:0] PC_DB_PIX    = 6'd31;
  localparam logic [PC_W-1:0] PC_DB_STEP   = 6'd32;
  localparam logic [PC_W-1:0] PC_READ      = 6'd33;
  localparam logic [PC_W-1:0] PC_EMIT      = 6'd34;

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] mode);
    logic [PC_W-1:0] pc;
    case (mode)
      MODE_CLEAR:   pc = PC_CLR;
      MODE_RECT:    pc = PC_RECT;
      MODE_UP_TRI:  pc = PC_UP_ROW;
      MODE_DN_TRI:  pc = PC_DN_ROW;
      MODE_DIAMOND: pc = PC_DIA;
      MODE_READ:    pc = PC_READ;
      default:      pc = PC_EMIT;
    endcase
    return pc;
  endfunction

  // Control store. Each span loop: test rows left, clip, skip empty span,
  // one pixel per step, then advance the row.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '0;
    case (pc)
      PC_IDLE: begin
        w.rdy = 1'b1; w.seq = SEQ_DISPATCH;
      end
      PC_RST_CLR: begin
        w.clr = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_CLR_MORE; w.target = PC_RST_CLR;
      end
      PC_RST_DONE: begin
        w.seq = SEQ_JUMP; w.target = PC_IDLE;
      end
      PC_CLR: begin
        w.clr = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_CLR_MORE; w.target = PC_CLR;
      end
      PC_CLR_DONE: begin
        w.seq = SEQ_JUMP; w.target = PC_EMIT;
      end
      // rectangle
      PC_RECT: begin
        w.seq = SEQ_BRANCH; w.cond = C_W_ZERO; w.target = PC_EMIT;
      end
      PC_RE_ROW: begin
        w.seq = SEQ_BRANCH; w.cond = C_ROWS_ZERO; w.target = PC_EMIT;
      end
      PC_RE_SET: begin
        w.row_setup = 1'b1; w.span_rect = 1'b1;
      end
      PC_RE_CHK: begin
        w.seq = SEQ_BRANCH; w.cond = C_SPAN_EMPTY; w.target = PC_RE_STEP;
      end
      PC_RE_PIX: begin
        w.pix = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_COL_MORE; w.target = PC_RE_PIX;
      end
      PC_RE_STEP: begin
        w.row_step = 1'b1; w.seq = SEQ_JUMP; w.target = PC_RE_ROW;
      end
      // up triangle
      PC_UP_ROW: begin
        w.seq = SEQ_BRANCH; w.cond = C_ROWS_ZERO; w.target = PC_EMIT;
      end
      PC_UP_SET: begin
        w.row_setup = 1'b1;
      end
      PC_UP_CHK: begin
        w.seq = SEQ_BRANCH; w.cond = C_SPAN_EMPTY; w.target = PC_UP_STEP;
      end
      PC_UP_PIX: begin
        w.pix = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_COL_MORE; w.target = PC_UP_PIX;
      end
      PC_UP_STEP: begin
        w.row_step = 1'b1; w.seq = SEQ_JUMP; w.target = PC_UP_ROW;
      end
      // down triangle
      PC_DN_ROW: begin
        w.seq = SEQ_BRANCH; w.cond = C_ROWS_ZERO; w.target = PC_EMIT;
      end
      PC_DN_SET: begin
        w.row_setup = 1'b1;
      end
      PC_DN_CHK: begin
        w.seq = SEQ_BRANCH; w.cond = C_SPAN_EMPTY; w.target = PC_DN_STEP;
      end
      PC_DN_PIX: begin
        w.pix = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_COL_MORE; w.target = PC_DN_PIX;
      end
      PC_DN_STEP: begin
        w.row_step = 1'b1; w.cy_down = 1'b1; w.seq = SEQ_JUMP; w.target = PC_DN_ROW;
      end
      // diamond, widening half
      PC_DIA: begin
        w.dm_init1 = 1'b1;
      end
      PC_DA_ROW: begin
        w.seq = SEQ_BRANCH; w.cond = C_ROWS_ZERO; w.target = PC_DIA2;
      end
      PC_DA_SET: begin
        w.row_setup = 1'b1;
      end
      PC_DA_CHK: begin
        w.seq = SEQ_BRANCH; w.cond = C_SPAN_EMPTY; w.target = PC_DA_STEP;
      end
      PC_DA_PIX: begin
        w.pix = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_COL_MORE; w.target = PC_DA_PIX;
      end
      PC_DA_STEP: begin
        w.row_step = 1'b1; w.seq = SEQ_JUMP; w.target = PC_DA_ROW;
      end
      // diamond, narrowing half
      PC_DIA2: begin
        w.dm_init2 = 1'b1;
      end
      PC_DB_ROW: begin
        w.seq = SEQ_BRANCH; w.cond = C_ROWS_ZERO; w.target = PC_EMIT;
      end
      PC_DB_SET: begin
        w.row_setup = 1'b1;
      end
      PC_DB_CHK: begin
        w.seq = SEQ_BRANCH; w.cond = C_SPAN_EMPTY; w.target = PC_DB_STEP;
      end
      PC_DB_PIX: begin
        w.pix = 1'b1; w.seq = SEQ_BRANCH; w.cond = C_COL_MORE; w.target = PC_DB_PIX;
      end
      PC_DB_STEP: begin
        w.row_step = 1'b1; w.hw_down = 1'b1; w.seq = SEQ_JUMP; w.target = PC_DB_ROW;
      end
      // read: one step for the registered memory read
      PC_READ: begin
        w.seq = SEQ_NEXT;
      end
      PC_EMIT: begin
        w.emit = 1'b1; w.seq = SEQ_WAIT; w.cond = C_OUT_BUSY; w.target = PC_IDLE;
      end
      default: begin
        w.seq = SEQ_JUMP; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ssr_if.sv =====
// Handshake channels of the shape span rasterizer: command words in, result words out.
// Depends on nothing.
interface ssr_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [7:0] x_pos;
  logic signed [7:0] y_pos;
  logic [6:0]        span_width;
  logic [6:0]        span_height;
  logic [7:0]        brush;

  modport source (output valid, mode, x_pos, y_pos, span_width, span_height, brush,
                  input ready);
  modport sink   (input valid, mode, x_pos, y_pos, span_width, span_height, brush,
                  output ready);
endinterface

interface ssr_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic        read_valid;
  logic [12:0] pixels_drawn;

  modport source (output valid, read_value, read_valid, pixels_drawn, input ready);
  modport sink   (input valid, read_value, read_valid, pixels_drawn, output ready);
endinterface

// ===== hdl/shape_span_rasterizer_unit.sv =====
// Top level of the shape span rasterizer: frame store, span datapath, APB registers.
// Depends on ssr_pkg, ssr_if (ssr_cmd_if, ssr_res_if) and ssr_sequencer.
//
//  channel  dir  handshake          word
//  -------  ---  -----------------  ----------------------------------------------
//  cmd      in   valid/ready        mode, x_pos, y_pos, span_width, span_height, brush
//  res      out  valid/ready        read_value, read_valid, pixels_drawn
//  apb      in   psel/penable       canvas_width @0x0, canvas_height @0x4, pready=1
//
//  Flow: one command at a time, one frame-store write per cycle. Each row walked is
//  tested, clipped, filled pixel by pixel and stepped; a clear sweeps the whole store.
//  Reset: synchronous; a blanking sweep of the whole frame store follows.
//  Stalls: a finished word waits in the result register while the next command is
//  taken; the sequencer only waits at its final step.
module shape_span_rasterizer_unit #(
  parameter int MAX_WIDTH  = ssr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ssr_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  ssr_cmd_if.sink     cmd,
  ssr_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW      = ssr_pkg::COORD_W;
  localparam int SW      = ssr_pkg::SIZE_W;
  localparam int DW      = ssr_pkg::DIM_W;

  localparam logic signed [CW-1:0] ONE  = 1;
  localparam logic signed [CW-1:0] ZERO = 0;
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]    ROW_PITCH = ADDR_W'(MAX_WIDTH);

  ssr_pkg::ctrl_word_t cw;
  ssr_pkg::flags_t     flags;

  // ---------------- configuration registers ----------------
  logic [ssr_pkg::CANVAS_W-1:0] canvas_width;
  logic [ssr_pkg::CANVAS_W-1:0] canvas_height;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == ssr_pkg::REG_HEIGHT) ? 32'(canvas_height) : 32'(canvas_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= ssr_pkg::CANVAS_RESET;
      canvas_height <= ssr_pkg::CANVAS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ssr_pkg::REG_HEIGHT) begin
        canvas_height <= pwdata[ssr_pkg::CANVAS_W-1:0];
      end else begin
        canvas_width <= pwdata[ssr_pkg::CANVAS_W-1:0];
      end
    end
  end

  // active clip bounds: register value capped at the store size
  logic [DW-1:0]          act_w;
  logic [DW-1:0]          act_h;
  logic signed [CW-1:0]   act_w_s;
  logic signed [CW-1:0]   act_h_s;

  assign act_w   = (DW'(canvas_width) < DW'(MAX_WIDTH)) ? DW'(canvas_width) : DW'(MAX_WIDTH);
  assign act_h   = (DW'(canvas_height) < DW'(MAX_HEIGHT)) ? DW'(canvas_height)
                                                          : DW'(MAX_HEIGHT);
  assign act_w_s = CW'(act_w);
  assign act_h_s = CW'(act_h);

  // ---------------- command registers ----------------
  logic                 accept;
  logic [2:0]           mode_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic [SW-1:0]        w_r;
  logic [SW-1:0]        h_r;
  logic [7:0]           brush_r;

  // span walker state
  logic signed [CW-1:0] cy;        // current row
  logic [SW-1:0]        hw;        // half width of triangle / diamond row
  logic [SW-1:0]        rows;      // rows left in this phase
  logic signed [CW-1:0] col;       // current column
  logic signed [CW-1:0] xe;        // last column of clipped span
  logic                 span_ok;
  logic [ssr_pkg::CNT_W-1:0] cnt;
  logic [ADDR_W-1:0]    clr_addr;

  assign cmd.ready = cw.rdy;
  assign accept    = cw.rdy & cmd.valid;

  // diamond phase sizes
  logic [SW-1:0]        dm_k;
  logic signed [CW-1:0] h_ext;
  assign dm_k  = (h_r == '0) ? '0 : h_r - 1'b1;
  assign h_ext = CW'(h_r);

  // span of current row, then clip
  logic signed [CW-1:0] hw_ext;
  logic signed [CW-1:0] w_ext;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] x1;
  logic signed [CW-1:0] xs_c;
  logic signed [CW-1:0] xe_c;
  logic signed [CW-1:0] wm1;
  logic                 row_in;

  assign hw_ext = CW'(hw);
  assign w_ext  = CW'(w_r);
  assign x0     = cw.span_rect ? x_r : x_r - hw_ext;
  assign x1     = cw.span_rect ? x_r + w_ext - ONE : x_r + hw_ext;
  assign wm1    = act_w_s - ONE;
  assign xs_c   = (x0 < ZERO) ? ZERO : x0;
  assign xe_c   = (x1 > wm1) ? wm1 : x1;
  assign row_in = (cy >= ZERO) && (cy < act_h_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (accept) begin
      clr_addr <= '0;
    end else if (cw.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= cmd.mode;
      x_r     <= CW'(cmd.x_pos);
      y_r     <= CW'(cmd.y_pos);
      w_r     <= cmd.span_width;
      h_r     <= cmd.span_height;
      brush_r <= cmd.brush;
      cy      <= CW'(cmd.y_pos);
      hw      <= '0;
      rows    <= cmd.span_height;
      cnt     <= '0;
    end else begin
      if (cw.dm_init1) begin
        rows <= dm_k;
      end
      // narrowing half starts on row y+h-1 (y-1 for a size-zero diamond)
      if (cw.dm_init2) begin
        cy   <= y_r + h_ext - ONE;
        hw   <= dm_k;
        rows <= dm_k + 1'b1;
      end
      if (cw.row_setup) begin
        col     <= xs_c;
        xe      <= xe_c;
        span_ok <= row_in && (xs_c <= xe_c);
      end
      if (cw.pix) begin
        col <= col + ONE;
        cnt <= cnt + 1'b1;
      end
      if (cw.row_step) begin
        cy   <= cw.cy_down ? cy - ONE : cy + ONE;
        hw   <= cw.hw_down ? hw - 1'b1 : hw + 1'b1;
        rows <= rows - 1'b1;
      end
    end
  end

  // ---------------- frame store ----------------
  logic [7:0]        frame_store [DEPTH];
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic              rd_in;

  assign pix_addr = ADDR_W'(ADDR_W'(cy[ROW_W-1:0]) * ROW_PITCH) + ADDR_W'(col[COL_W-1:0]);
  assign rd_addr  = ADDR_W'(ADDR_W'(y_r[ROW_W-1:0]) * ROW_PITCH) + ADDR_W'(x_r[COL_W-1:0]);
  assign wr_en    = cw.clr | cw.pix;
  assign wr_addr  = cw.clr ? clr_addr : pix_addr;
  assign wr_data  = cw.clr ? ssr_pkg::BLANK_PIXEL : brush_r;
  assign rd_in    = (x_r >= ZERO) && (x_r < act_w_s) && (y_r >= ZERO) && (y_r < act_h_s);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= frame_store[rd_addr];
  end

  // ---------------- result register ----------------
  logic                      out_valid;
  logic [7:0]                out_value;
  logic                      out_rvalid;
  logic [ssr_pkg::CNT_W-1:0] out_drawn;
  logic                      out_busy;
  logic                      emit_fire;
  logic                      is_read;

  assign out_busy  = out_valid & ~res.ready;
  assign emit_fire = cw.emit & ~out_busy;
  assign is_read   = (mode_r == ssr_pkg::MODE_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value  <= (is_read && rd_in) ? rd_data : 8'd0;
      out_rvalid <= is_read && rd_in;
      out_drawn  <= cnt;
    end
  end

  assign res.valid        = out_valid;
  assign res.read_value   = out_value;
  assign res.read_valid   = out_rvalid;
  assign res.pixels_drawn = out_drawn;

  // ---------------- sequencer ----------------
  assign flags.accept     = accept;
  assign flags.mode       = cmd.mode;
  assign flags.rows_zero  = (rows == '0);
  assign flags.span_empty = ~span_ok;
  assign flags.col_more   = (col != xe);
  assign flags.clr_more   = (clr_addr != LAST_ADDR);
  assign flags.out_busy   = out_busy;
  assign flags.w_zero     = (w_r == '0);

  ssr_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

endmodule

// ===== hdl/ssr_sequencer.sv =====
// Step counter and control store of the rasterizer; issues one control word per cycle.
// Depends on ssr_pkg (control word, flags, program).
module ssr_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  ssr_pkg::flags_t     flags,
  output ssr_pkg::ctrl_word_t cw
);

  logic [ssr_pkg::PC_W-1:0] pc;
  logic [ssr_pkg::PC_W-1:0] pc_next;
  logic                     cond_hit;

  assign cw = ssr_pkg::ucode(pc);

  always_comb begin
    case (cw.cond)
      ssr_pkg::C_ROWS_ZERO:  cond_hit = flags.rows_zero;
      ssr_pkg::C_SPAN_EMPTY: cond_hit = flags.span_empty;
      ssr_pkg::C_COL_MORE:   cond_hit = flags.col_more;
      ssr_pkg::C_CLR_MORE:   cond_hit = flags.clr_more;
      ssr_pkg::C_OUT_BUSY:   cond_hit = flags.out_busy;
      ssr_pkg::C_W_ZERO:     cond_hit = flags.w_zero;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.seq)
      ssr_pkg::SEQ_NEXT:     pc_next = pc + 1'b1;
      ssr_pkg::SEQ_JUMP:     pc_next = cw.target;
      ssr_pkg::SEQ_BRANCH:   pc_next = cond_hit ? cw.target : pc + 1'b1;
      ssr_pkg::SEQ_WAIT:     pc_next = cond_hit ? pc : cw.target;
      ssr_pkg::SEQ_DISPATCH: pc_next = flags.accept ? ssr_pkg::entry_pc(flags.mode) : pc;
      default:               pc_next = ssr_pkg::PC_IDLE;
    endcase
  end

  // reset starts the blanking sweep of the frame store
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ssr_pkg::PC_RST_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/ssr_checker.sv =====
// Port-level checks of the shape span rasterizer, bound to its top level.
// Depends on shape_span_rasterizer_unit (bind target) only.
module ssr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  read_value,
  input logic        read_valid,
  input logic [12:0] pixels_drawn
);

  // the blanking sweep follows reset, so no command is taken right away
  a_no_take_after_reset: assert property (@(posedge clk)
    disable iff (rst) $past(rst) |-> !cmd_ready)
    else $error("command ready right after reset");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk)
    disable iff (rst) (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("second command taken while one is in work");

  // a read draws nothing; a missed read returns zero
  a_read_draws_none: assert property (@(posedge clk)
    disable iff (rst) (res_valid && read_valid) |-> (pixels_drawn == 13'd0))
    else $error("read result with nonzero pixel count");

  a_miss_is_zero: assert property (@(posedge clk)
    disable iff (rst) (res_valid && !read_valid) |-> (read_value == 8'd0))
    else $error("nonzero read value without read_valid");

  a_res_hold: assert property (@(posedge clk)
    disable iff (rst) (res_valid && !res_ready) |=>
      (res_valid && $stable(read_value) && $stable(read_valid) && $stable(pixels_drawn)))
    else $error("stalled result word changed");

endmodule

bind shape_span_rasterizer_unit ssr_checker u_ssr_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .read_value   (res.read_value),
  .read_valid   (res.read_valid),
  .pixels_drawn (res.pixels_drawn)
);

// ===== bench/ssr_raster_checker.sv =====
`timescale 1ns / 1ps
// Checker for the shape span rasterizer: keeps a copy of the frame store and the canvas
// bounds, predicts each result word and compares it with what the block returns.
// Depends on ssr_pkg and the channel interfaces ssr_cmd_if and ssr_res_if.
module ssr_raster_checker #(
  parameter int MAX_WIDTH  = ssr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ssr_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  ssr_cmd_if          cmd,
  ssr_res_if          res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          outstanding,
  output int          fail_count
);
  import ssr_pkg::*;

  typedef struct packed {
    logic [7:0]  value;
    logic        hit;
    logic [12:0] drawn;
  } raster_word_t;

  logic [7:0]   frame_copy [MAX_WIDTH*MAX_HEIGHT];
  logic [6:0]   canvas_cols;
  logic [6:0]   canvas_rows;
  raster_word_t pending_words [$];
  int           errors = 0;

  assign fail_count = errors;

  // register values above the store size clip at the store size
  function automatic int active_cols();
    return (int'(canvas_cols) < MAX_WIDTH) ? int'(canvas_cols) : MAX_WIDTH;
  endfunction

  function automatic int active_rows();
    return (int'(canvas_rows) < MAX_HEIGHT) ? int'(canvas_rows) : MAX_HEIGHT;
  endfunction

  // fill columns x0..x1 of one row, clipped to the canvas; returns pixels written
  function automatic int paint_row(int row, int x0, int x1, logic [7:0] ink);
    int lo, hi, col, n;
    n = 0;
    if (row < 0 || row >= active_rows()) return 0;
    lo = (x0 < 0) ? 0 : x0;
    hi = (x1 > active_cols() - 1) ? active_cols() - 1 : x1;
    for (col = lo; col <= hi; col++) begin
      frame_copy[row * MAX_WIDTH + col] = ink;
      n++;
    end
    return n;
  endfunction

  function automatic raster_word_t rasterize(logic [2:0] op, logic signed [7:0] xs,
                                             logic signed [7:0] ys, logic [6:0] w,
                                             logic [6:0] h, logic [7:0] ink);
    raster_word_t word;
    int x, y, cols, rows, r, k, total;
    word  = '0;
    total = 0;
    x     = xs;
    y     = ys;
    cols  = w;
    rows  = h;
    case (op)
      MODE_CLEAR: begin
        foreach (frame_copy[i]) frame_copy[i] = BLANK_PIXEL;
      end
      MODE_RECT: begin
        if (cols > 0)
          for (r = 0; r < rows; r++) total += paint_row(y + r, x, x + cols - 1, ink);
      end
      MODE_UP_TRI: begin
        for (r = 0; r < rows; r++) total += paint_row(y + r, x - r, x + r, ink);
      end
      MODE_DN_TRI: begin
        for (r = 0; r < rows; r++) total += paint_row(y - r, x - r, x + r, ink);
      end
      MODE_DIAMOND: begin
        // widen for d-1 rows, then widest row and narrow back to a point;
        // size zero lands on the one pixel just above the anchor
        for (r = 0; r < rows - 1; r++) total += paint_row(y + r, x - r, x + r, ink);
        k = (rows >= 1) ? rows - 1 : 0;
        for (r = 0; k - r >= 0; r++)
          total += paint_row(y + rows - 1 + r, x - (k - r), x + (k - r), ink);
      end
      MODE_READ: begin
        if (x >= 0 && x < active_cols() && y >= 0 && y < active_rows()) begin
          word.value = frame_copy[y * MAX_WIDTH + x];
          word.hit   = 1'b1;
        end
      end
      default: ;
    endcase
    word.drawn = total[12:0];
    return word;
  endfunction

  task automatic check_field(input string name, input logic [12:0] got,
                             input logic [12:0] want);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    raster_word_t want;
    if (rst) begin
      foreach (frame_copy[i]) frame_copy[i] = BLANK_PIXEL;
      canvas_cols = CANVAS_RESET;
      canvas_rows = CANVAS_RESET;
      pending_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEIGHT) canvas_rows = pwdata[6:0];
        else canvas_cols = pwdata[6:0];
      end
      if (res.valid && res.ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t ns: result word with none expected, actual value %0d hit %0d drawn %0d",
                   $time, res.read_value, res.read_valid, res.pixels_drawn);
          errors++;
        end else begin
          want = pending_words.pop_front();
          check_field("read_value", 13'(res.read_value), 13'(want.value));
          check_field("read_valid", 13'(res.read_valid), 13'(want.hit));
          check_field("pixels_drawn", res.pixels_drawn, want.drawn);
        end
      end
      if (cmd.valid && cmd.ready)
        pending_words.insert(pending_words.size(),
                             rasterize(cmd.mode, cmd.x_pos, cmd.y_pos,
                                       cmd.span_width, cmd.span_height, cmd.brush));
    end
    outstanding <= pending_words.size();
  end

endmodule

// ===== bench/tb_shape_span_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// Top of the shape span rasterizer bench: clock, reset, command stimulus, result stall
// pattern and APB canvas writes. Depends on ssr_pkg, ssr_if, the block and ssr_raster_checker.
module tb_shape_span_rasterizer_unit;
  import ssr_pkg::*;

  // modes the block decodes to a no-op
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  // A clear and a full-height shape are the costly commands; with a few of
  // each plus the reset sweep the run sits well below this bound.
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SEGMENT_WORDS    = 100;
  localparam int LONG_HOLD_AT     = 180;   // result count that starts the long stall
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 16;

  // canvas setting and idle pattern per random segment; 127 checks clipping at the store
  localparam logic [6:0] COLS_PLAN [5] = '{7'd64, 7'd17, 7'd127, 7'd1, 7'd40};
  localparam logic [6:0] ROWS_PLAN [5] = '{7'd64, 7'd40, 7'd127, 7'd63, 7'd9};
  localparam int SEND_IDLE_PLAN [5] = '{20, 20, 59, 59, 0};
  localparam int RECV_IDLE_PLAN [5] = '{59, 59, 20, 20, 0};

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int outstanding;
  int fail_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  ssr_cmd_if cmd_ch ();
  ssr_res_if res_ch ();

  shape_span_rasterizer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ssr_raster_checker raster_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial forever #2 clk = ~clk;

  // hard stop on a hang
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Result side. Random stalls per the current idle pattern, plus one long
  // hold-off mid-run: the result register fills, the sequencer parks at its
  // final step and cmd.ready drops while the sender keeps offering words.
  initial begin
    int  results_seen;
    bit  long_hold_done;
    results_seen   = 0;
    long_hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) results_seen++;
      if (results_seen == LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one command word, with random idle cycles ahead of it. valid is only
  // dropped when a gap is actually taken, so back-to-back words keep it high.
  task automatic send_word(input logic [2:0] op, input logic signed [7:0] xs,
                           input logic signed [7:0] ys, input logic [6:0] w,
                           input logic [6:0] h, input logic [7:0] ink);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.mode        <= op;
    cmd_ch.x_pos       <= xs;
    cmd_ch.y_pos       <= ys;
    cmd_ch.span_width  <= w;
    cmd_ch.span_height <= h;
    cmd_ch.brush       <= ink;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Hold the sender until every predicted word is back. The checker's count
  // is registered, so the task waits on the clock before it reads it.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Both canvas registers back to back; psel stays up between the two transfers.
  // Upper data bits are junk, the registers keep only 7 bits.
  task automatic set_canvas(input logic [6:0] cols, input logic [6:0] rows);
    int sel;
    for (sel = 0; sel < 2; sel++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {(sel == 0) ? REG_WIDTH : REG_HEIGHT, 2'b00};
      pwdata  <= {25'($urandom), (sel == 0) ? cols : rows};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int               seg, n, pick;
    logic [2:0]       op;
    logic signed [7:0] xs, ys;
    logic [6:0]       w, h;

    cmd_ch.valid       <= 1'b0;
    cmd_ch.mode        <= MODE_CLEAR;
    cmd_ch.x_pos       <= '0;
    cmd_ch.y_pos       <= '0;
    cmd_ch.span_width  <= '0;
    cmd_ch.span_height <= '0;
    cmd_ch.brush       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // --- directed, default 64x64 canvas; the first word waits out the reset sweep
    send_word(MODE_READ, 8'sd0, 8'sd0, 7'd0, 7'd0, 8'h00);          // blank after reset
    send_word(MODE_RECT, 8'sd0, 8'sd0, 7'd127, 7'd127, 8'h55);      // whole canvas, 4096
    send_word(MODE_READ, 8'sd63, 8'sd63, 7'd0, 7'd0, 8'h00);
    send_word(MODE_CLEAR, 8'sd0, 8'sd0, 7'd0, 7'd0, 8'h00);
    send_word(MODE_READ, 8'sd63, 8'sd63, 7'd0, 7'd0, 8'h00);        // blank again
    send_word(MODE_RECT, 8'sh80, 8'sh80, 7'd127, 7'd127, 8'hff);    // fully off canvas
    send_word(MODE_RECT, 8'sd60, 8'sd60, 7'd0, 7'd5, 8'h11);        // zero width
    send_word(MODE_RECT, 8'sd10, 8'sd10, 7'd5, 7'd0, 8'h22);        // zero height
    send_word(MODE_UP_TRI, 8'sd32, 8'sd0, 7'd0, 7'd40, 8'h00);
    send_word(MODE_DN_TRI, 8'sd32, 8'sd63, 7'd127, 7'd40, 8'hff);
    send_word(MODE_UP_TRI, 8'sd5, 8'sd5, 7'd3, 7'd0, 8'h33);        // zero height
    send_word(MODE_DIAMOND, 8'sd10, 8'sd10, 7'd0, 7'd0, 8'h81);     // size zero
    send_word(MODE_READ, 8'sd10, 8'sd9, 7'd0, 7'd0, 8'h00);         // pixel above anchor
    send_word(MODE_DIAMOND, 8'sd32, 8'sd20, 7'd0, 7'd1, 8'h44);
    send_word(MODE_DIAMOND, 8'sd20, -8'sd30, 7'd0, 7'd127, 8'h66);  // huge, mostly clipped
    send_word(MODE_READ, 8'sh7f, 8'sh7f, 7'd0, 7'd0, 8'h00);        // outside canvas
    send_word(MODE_READ, -8'sd1, 8'sd5, 7'd0, 7'd0, 8'h00);         // outside canvas
    send_word(MODE_SPARE_A, 8'sd3, 8'sd3, 7'd4, 7'd4, 8'h77);       // no-op modes
    send_word(MODE_SPARE_B, 8'sh80, 8'sh7f, 7'd127, 7'd127, 8'hff);
    send_word(MODE_RECT, 8'sh7f, 8'sh80, 7'd127, 7'd127, 8'h99);

    // empty canvas: everything clips, reads miss
    drain_results();
    set_canvas(7'd0, 7'd0);
    send_word(MODE_RECT, 8'sd0, 8'sd0, 7'd10, 7'd10, 8'h12);
    send_word(MODE_READ, 8'sd0, 8'sd0, 7'd0, 7'd0, 8'h00);

    // oversized registers clip at the store size; the frame survives the writes
    drain_results();
    set_canvas(7'd127, 7'd127);
    send_word(MODE_READ, 8'sd63, 8'sd63, 7'd0, 7'd0, 8'h00);
    send_word(MODE_RECT, 8'sd50, 8'sd50, 7'd127, 7'd127, 8'h3c);

    // --- random segments, each with its own canvas and idle pattern
    for (seg = 0; seg < 5; seg++) begin
      drain_results();
      set_canvas(COLS_PLAN[seg], ROWS_PLAN[seg]);
      send_idle_pct = SEND_IDLE_PLAN[seg];
      recv_idle_pct = RECV_IDLE_PLAN[seg];
      for (n = 0; n < SEGMENT_WORDS; n++) begin
        // one full pause of the sender midway through segment 3
        if (seg == 3 && n == SEGMENT_WORDS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 2) op = MODE_CLEAR;
        else if (pick < 24) op = MODE_RECT;
        else if (pick < 42) op = MODE_UP_TRI;
        else if (pick < 60) op = MODE_DN_TRI;
        else if (pick < 74) op = MODE_DIAMOND;
        else if (pick < 96) op = MODE_READ;
        else if (pick < 98) op = MODE_SPARE_A;
        else op = MODE_SPARE_B;
        // mostly on or near the canvas, sometimes anywhere
        if ($urandom_range(0, 9) == 0) xs = 8'($urandom);
        else xs = 8'($urandom_range(0, 78) - 8);
        if ($urandom_range(0, 9) == 0) ys = 8'($urandom);
        else ys = 8'($urandom_range(0, 78) - 8);
        // small shapes keep the run short; an occasional one spans the full range
        if ($urandom_range(0, 32) == 0) w = 7'($urandom_range(0, 127));
        else w = 7'($urandom_range(0, 10));
        if ($urandom_range(0, 32) == 0) h = 7'($urandom_range(0, 127));
        else h = 7'($urandom_range(0, 10));
        send_word(op, xs, ys, w, h, 8'($urandom));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ssr_pkg.sv
hdl/ssr_if.sv
hdl/ssr_sequencer.sv
hdl/shape_span_rasterizer_unit.sv
hdl/ssr_checker.sv
bench/ssr_raster_checker.sv
bench/tb_shape_span_rasterizer_unit.sv
